>>> sv/lcdq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lcdq_pkg
// Shared types and constants for the character-LCD write queue.
// ---------------------------------------------------------------------------
package lcdq_pkg;

  // Request status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_BUSY = 2'd2,
    ST_FULL = 2'd3
  } lcdq_status_t;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  // Item function
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Register select
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // DDRAM address command
  localparam logic [7:0] ADDR_CMD_BASE = 8'h80;
  localparam logic [7:0] ROW2_OFFSET   = 8'h40;
  localparam logic [7:0] MAX_COLUMN    = 8'd40;
  localparam logic [7:0] ROW_ONE       = 8'd1;
  localparam logic [7:0] ROW_TWO       = 8'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEND,
    S_CHAR,
    S_OUT
  } lcdq_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;   // latch input word
    logic do_first;  // row/column check, address command push
    logic do_char;   // character push, status result on last
    logic do_send;   // load LCD write result from queue
  } lcdq_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic can_send;
    logic first;
    logic in_request;
    logic last;
  } lcdq_stat_t;

endpackage : lcdq_pkg
`default_nettype wire

>>> sv/lcdq_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lcdq_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lcdq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : lcdq_ram
`default_nettype wire

>>> sv/lcdq_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lcdq_ctrl
// Sequencer: steps each accepted word through decode, push or send, and
// result hand-off.
// ---------------------------------------------------------------------------
module lcdq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire lcdq_pkg::lcdq_stat_t stat,
  output lcdq_pkg::lcdq_cmd_t      cmd
);
  import lcdq_pkg::*;

  lcdq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.is_tick) begin
          state_next = stat.can_send ? S_SEND : S_IDLE;
        end else if (stat.first || stat.in_request) begin
          state_next = S_CHAR;
        end else begin
          state_next = S_IDLE;   // stray character word
        end
      end
      S_SEND:  state_next = S_OUT;
      S_CHAR:  state_next = stat.last ? S_OUT : S_IDLE;
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: cmd.do_first = !stat.is_tick && stat.first;
      S_SEND:   cmd.do_send  = 1'b1;
      S_CHAR:   cmd.do_char  = 1'b1;
      S_OUT:    out_valid    = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule : lcdq_ctrl
`default_nettype wire

>>> sv/lcdq_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lcdq_dpath
// Input word register, queue RAM and pointers, tick check and result
// register.
// ---------------------------------------------------------------------------
module lcdq_dpath #(
  parameter int QUEUE_DEPTH = 24
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lcdq_pkg::lcdq_cmd_t cmd,
  output lcdq_pkg::lcdq_stat_t     stat,
  input  wire logic                func,
  input  wire logic [7:0]          row,
  input  wire logic [7:0]          column,
  input  wire logic [7:0]          char_code,
  input  wire logic                has_char,
  input  wire logic                first,
  input  wire logic                last,
  input  wire logic [15:0]         tick_now,
  output logic                     kind,
  output logic [1:0]               status,
  output logic                     busy_res,
  output logic                     lcd_rs,
  output logic [7:0]               lcd_data
);
  import lcdq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // captured input word
  logic        w_func, w_has_char, w_first, w_last;
  logic [7:0]  w_row, w_column, w_char;
  logic [15:0] w_tick;

  // queue control state
  logic [CW-1:0] queue_length, queue_length_next;
  logic [CW-1:0] send_position, send_position_next;
  logic [15:0]   next_send_tick, next_send_tick_next;
  lcdq_status_t  request_status, request_status_next;
  logic          in_request, in_request_next;

  // RAM ports
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [8:0]    wr_data;
  logic [8:0]    rd_data;

  logic [15:0] tick_diff;
  logic        bad_pos;
  logic [7:0]  addr_cmd;
  logic [CW-1:0] send_inc;

  // result register
  logic         res_kind, res_busy, res_rs;
  lcdq_status_t res_status;
  logic [7:0]   res_data;

  lcdq_ram #(
    .WIDTH(9),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(send_position[IW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w_func     <= func;
      w_row      <= row;
      w_column   <= column;
      w_char     <= char_code;
      w_has_char <= has_char;
      w_first    <= first;
      w_last     <= last;
      w_tick     <= tick_now;
    end
  end

  assign tick_diff = w_tick - next_send_tick;
  assign bad_pos   = (w_row != ROW_ONE && w_row != ROW_TWO) ||
                     (w_column == 8'd0) || (w_column > MAX_COLUMN);
  assign addr_cmd  = ADDR_CMD_BASE + w_column - 8'd1 +
                     ((w_row == ROW_TWO) ? ROW2_OFFSET : 8'd0);
  assign send_inc  = send_position + ONE_C;

  always_comb begin
    stat.is_tick    = (w_func == FUNC_TICK);
    stat.can_send   = (send_position < queue_length) && !tick_diff[15];
    stat.first      = w_first;
    stat.in_request = in_request;
    stat.last       = w_last;
  end

  always_comb begin
    queue_length_next   = queue_length;
    send_position_next  = send_position;
    next_send_tick_next = next_send_tick;
    request_status_next = request_status;
    in_request_next     = in_request;
    wr_en   = 1'b0;
    wr_addr = queue_length[IW-1:0];
    wr_data = {RS_DATA, w_char};

    if (cmd.do_first) begin
      in_request_next = 1'b1;
      if (bad_pos) begin
        request_status_next = ST_BAD;
      end else if (queue_length != '0) begin
        request_status_next = ST_BUSY;
      end else begin
        // empty queue, depth is at least two: the command always fits
        wr_en               = 1'b1;
        wr_addr             = '0;
        wr_data             = {RS_CMD, addr_cmd};
        queue_length_next   = ONE_C;
        send_position_next  = '0;
        request_status_next = ST_OK;
      end
    end

    if (cmd.do_char) begin
      if (w_has_char && request_status == ST_OK) begin
        if (queue_length < DEPTH_C) begin
          wr_en             = 1'b1;
          queue_length_next = queue_length + ONE_C;
        end else begin
          request_status_next = ST_FULL;
        end
      end
      if (w_last) in_request_next = 1'b0;
    end

    if (cmd.do_send) begin
      next_send_tick_next = w_tick + 16'd1;
      if (send_inc >= queue_length) begin
        queue_length_next  = '0;
        send_position_next = '0;
      end else begin
        send_position_next = send_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_length   <= '0;
      send_position  <= '0;
      next_send_tick <= '0;
      request_status <= ST_OK;
      in_request     <= 1'b0;
    end else begin
      queue_length   <= queue_length_next;
      send_position  <= send_position_next;
      next_send_tick <= next_send_tick_next;
      request_status <= request_status_next;
      in_request     <= in_request_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_send) begin
      res_kind   <= KIND_WRITE;
      res_status <= ST_OK;
      res_busy   <= (send_position_next < queue_length_next);
      res_rs     <= rd_data[8];
      res_data   <= rd_data[7:0];
    end else if (cmd.do_char && w_last) begin
      res_kind   <= KIND_STATUS;
      res_status <= request_status_next;
      res_busy   <= (send_position_next < queue_length_next);
      res_rs     <= RS_CMD;
      res_data   <= 8'd0;
    end
  end

  assign kind     = res_kind;
  assign status   = res_status;
  assign busy_res = res_busy;
  assign lcd_rs   = res_rs;
  assign lcd_data = res_data;

endmodule : lcdq_dpath
`default_nettype wire

>>> sv/lcd_text_write_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lcd_text_write_queue
// Character-LCD write queue: text requests fill a queue of address and
// character entries, tick words drain it one LCD write at a time.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | func row column char_code has_char first
//          |                      | last tick_now
//  out     | out_valid / out_ready| kind status busy_res lcd_rs lcd_data
//
// Flow: a word is taken in IDLE and decoded the cycle after. A character
// word passes capture, request check and character push; a tick that
// sends passes capture, queue RAM read and result load. A word with a result
// then holds the result register until out_ready, so one word is in work at
// a time; the queue RAM's registered read port sets the send path length.
// A word with no result (stray character, tick with nothing due) frees the
// input once it is decoded.
// Reset (rst, synchronous) empties the queue pointers, clears the request
// state and the tick limit; RAM contents are not cleared and not needed.
// Stalls: in_ready is low from capture until the word, and any result, is done.
//
module lcd_text_write_queue #(
  parameter int QUEUE_DEPTH = 24   // queue entries, 2..255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  row,
  input  wire logic [7:0]  column,
  input  wire logic [7:0]  char_code,
  input  wire logic        has_char,
  input  wire logic        first,
  input  wire logic        last,
  input  wire logic [15:0] tick_now,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [1:0]       status,
  output logic             busy_res,
  output logic             lcd_rs,
  output logic [7:0]       lcd_data
);
  import lcdq_pkg::*;

  lcdq_cmd_t  cmd;
  lcdq_stat_t stat;

  // sequencer
  lcdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queue, pointers, tick check, result register
  lcdq_dpath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .func     (func),
    .row      (row),
    .column   (column),
    .char_code(char_code),
    .has_char (has_char),
    .first    (first),
    .last     (last),
    .tick_now (tick_now),
    .kind     (kind),
    .status   (status),
    .busy_res (busy_res),
    .lcd_rs   (lcd_rs),
    .lcd_data (lcd_data)
  );

endmodule : lcd_text_write_queue
`default_nettype wire

>>> bench/lcdq_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lcdq_result_checker
// Watches both channels of the LCD write queue, keeps a shadow queue with
// the request and tick-limit state, and compares every result word against
// the oldest predicted one. Mismatches are counted and handed to the bench.
// ---------------------------------------------------------------------------
module lcdq_result_checker #(
  parameter int QUEUE_DEPTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [7:0]  row,
  input  logic [7:0]  column,
  input  logic [7:0]  char_code,
  input  logic        has_char,
  input  logic        first,
  input  logic        last,
  input  logic [15:0] tick_now,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [1:0]  status,
  input  logic        busy_res,
  input  logic        lcd_rs,
  input  logic [7:0]  lcd_data,
  output int          mismatches,
  output int          results_due,
  output int          ok_seen,
  output int          bad_seen,
  output int          busy_seen,
  output int          full_seen,
  output int          writes_seen
);
  import lcdq_pkg::*;

  typedef struct packed {
    logic         kind;
    lcdq_status_t status;
    logic         busy;
    logic         rs;
    logic [7:0]   data;
  } lcd_result_t;

  // shadow of the queue and the request state
  logic         entry_is_data [QUEUE_DEPTH];
  logic [7:0]   entry_byte    [QUEUE_DEPTH];
  int           q_fill;
  int           q_sent;
  logic [15:0]  earliest_tick;
  lcdq_status_t req_status;
  logic         req_open;

  lcd_result_t  lcd_results_due [$];

  function automatic logic push_entry(input logic is_data, input logic [7:0] value);
    if (q_fill >= QUEUE_DEPTH) return 1'b0;
    entry_is_data[q_fill] = is_data;
    entry_byte[q_fill]    = value;
    q_fill++;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : predict_lcd_results
    lcd_result_t want;
    logic [15:0] lag;
    logic [7:0]  addr;
    if (rst) begin
      q_fill        = 0;
      q_sent        = 0;
      earliest_tick = '0;
      req_status    = ST_OK;
      req_open      = 1'b0;
      lcd_results_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (func == FUNC_TICK) begin
          // wrap-safe: send only when tick is not behind the limit
          lag = tick_now - earliest_tick;
          if (q_sent < q_fill && !lag[15]) begin
            want.kind   = KIND_WRITE;
            want.status = ST_OK;
            want.rs     = entry_is_data[q_sent];
            want.data   = entry_byte[q_sent];
            q_sent++;
            earliest_tick = tick_now + 16'd1;
            if (q_sent >= q_fill) begin
              q_fill = 0;
              q_sent = 0;
            end
            want.busy = (q_sent < q_fill);
            lcd_results_due.push_back(want);
          end
        end else if (first || req_open) begin
          if (first) begin
            req_open = 1'b1;
            if ((row != ROW_ONE && row != ROW_TWO) || column == 8'd0 ||
                column > MAX_COLUMN) begin
              req_status = ST_BAD;
            end else if (q_fill != 0) begin
              req_status = ST_BUSY;
            end else begin
              addr = ADDR_CMD_BASE + column - 8'd1;
              if (row == ROW_TWO) addr = addr + ROW2_OFFSET;
              q_sent = 0;
              if (push_entry(RS_CMD, addr)) req_status = ST_OK;
              else req_status = ST_FULL;
            end
          end
          if (has_char && req_status == ST_OK && !push_entry(RS_DATA, char_code))
            req_status = ST_FULL;
          if (last) begin
            req_open = 1'b0;
            want = '{KIND_STATUS, req_status, (q_sent < q_fill), RS_CMD, 8'h00};
            lcd_results_due.push_back(want);
          end
        end
      end

      if (out_valid && out_ready) begin
        if (lcd_results_due.size() == 0) begin
          $error("result word with nothing due: kind %0d status %0d lcd_data 0x%0h",
                 kind, status, lcd_data);
          mismatches++;
        end else begin
          want = lcd_results_due.pop_front();
          check_field("kind",     8'(want.kind),   8'(kind));
          check_field("status",   8'(want.status), 8'(status));
          check_field("busy_res", 8'(want.busy),   8'(busy_res));
          check_field("lcd_rs",   8'(want.rs),     8'(lcd_rs));
          check_field("lcd_data", want.data,       lcd_data);
          if (want.kind == KIND_WRITE) begin
            writes_seen++;
          end else begin
            case (want.status)
              ST_OK:   ok_seen++;
              ST_BAD:  bad_seen++;
              ST_BUSY: busy_seen++;
              default: full_seen++;
            endcase
          end
        end
      end
    end
    results_due = lcd_results_due.size();
  end

endmodule

>>> bench/tb_lcd_text_write_queue.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lcd_text_write_queue
// Drives text requests and tick words into the LCD write queue with random
// gaps and output back-pressure; a checker beside the block predicts and
// compares every result word. This module gives the verdict.
// ---------------------------------------------------------------------------
module tb_lcd_text_write_queue;
  import lcdq_pkg::*;

  localparam int QUEUE_DEPTH   = 24;
  localparam int CLK_HALF      = 5;
  localparam int WORD_TARGET   = 1300;  // random part stops near this count
  localparam int MAX_GAP       = 60;    // longest sender gap, in cycles
  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
  localparam int SETTLE_CYCLES = 20;    // settle wait before the verdict

  // one input word, field order as on the ports
  typedef struct packed {
    logic        func;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [7:0]  char_code;
    logic        has_char;
    logic        first;
    logic        last;
    logic [15:0] tick_now;
  } lcd_word_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        func      = FUNC_CHAR;
  logic [7:0]  row       = '0;
  logic [7:0]  column    = '0;
  logic [7:0]  char_code = '0;
  logic        has_char  = 1'b0;
  logic        first     = 1'b0;
  logic        last      = 1'b0;
  logic [15:0] tick_now  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [1:0]  status;
  logic        busy_res;
  logic        lcd_rs;
  logic [7:0]  lcd_data;

  int mismatches, results_due;
  int ok_seen, bad_seen, busy_seen, full_seen, writes_seen;

  int          tx_idle_pct = 29;  // sender idle share, percent
  int          rx_idle_pct = 84;  // receiver stall share, percent
  int          words_sent  = 0;
  int          quiet_cycles = 0;
  logic [15:0] tick_clock  = '0;  // running millisecond count for ticks

  always #CLK_HALF clk = ~clk;

  lcd_text_write_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (.*);

  lcdq_result_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // watchdog: cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("watchdog: no handshake for %0d cycles, %0d results still due",
             STALL_LIMIT, results_due);
    $display("tb_lcd_text_write_queue: FAIL");
    $finish;
  end

  // Present one word after a random gap and hold it until taken. With no
  // gap, valid simply stays high into the next word.
  task automatic send_word(input lcd_word_t w);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= w.func;
    row       <= w.row;
    column    <= w.column;
    char_code <= w.char_code;
    has_char  <= w.has_char;
    first     <= w.first;
    last      <= w.last;
    tick_now  <= w.tick_now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // character word; tick_now is don't-care here, so it carries noise
  task automatic send_char(input logic [7:0] r, input logic [7:0] c, input logic [7:0] ch,
                           input logic hc, input logic fi, input logic la);
    send_word('{FUNC_CHAR, r, c, ch, hc, fi, la, 16'($urandom)});
  endtask

  // tick word; the request fields are ignored on ticks, so they carry noise
  task automatic send_tick(input logic [15:0] t);
    tick_clock = t;
    send_word('{FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                1'($urandom), 1'($urandom), t});
  endtask

  // Mostly a steady clock; sometimes a repeat or a step back (too early),
  // a jump near half the range, or anywhere at all.
  function automatic logic [15:0] drift_tick();
    int pick;
    pick = $urandom_range(99);
    if (pick < 72) return tick_clock + 16'($urandom_range(1, 3));
    else if (pick < 84) return tick_clock;
    else if (pick < 92) return tick_clock - 16'($urandom_range(1, 4));
    else if (pick < 96) return tick_clock + 16'h7FF0 + 16'($urandom_range(0, 31));
    else return 16'($urandom);
  endfunction

  // One text request: mostly a legal row/column and a short text, some long
  // enough to overrun the queue, a few left open without a last word.
  task automatic random_request(output int n_chars);
    int          shape;
    logic [7:0]  r;
    logic [7:0]  c;
    logic        open_end;
    shape = $urandom_range(99);
    if ($urandom_range(99) < 88) r = 8'($urandom_range(1, 2));
    else begin
      case ($urandom_range(3))
        0:       r = 8'd0;
        1:       r = 8'd3;
        2:       r = 8'hFF;
        default: r = 8'($urandom);
      endcase
    end
    if ($urandom_range(99) < 88) c = 8'($urandom_range(1, 40));
    else begin
      case ($urandom_range(3))
        0:       c = 8'd0;
        1:       c = MAX_COLUMN + 8'd1;
        2:       c = 8'hFF;
        default: c = 8'($urandom);
      endcase
    end
    if (shape < 78) n_chars = $urandom_range(1, 8);
    else if (shape < 92) n_chars = $urandom_range(QUEUE_DEPTH - 4, QUEUE_DEPTH + 2);
    else n_chars = $urandom_range(1, 4);
    open_end = (shape >= 92);
    for (int i = 0; i < n_chars; i++) begin
      // a rare tick in the middle of a request
      if (i > 0 && $urandom_range(99) < 3) send_tick(drift_tick());
      send_char((i == 0) ? r : 8'($urandom), (i == 0) ? c : 8'($urandom), 8'($urandom),
                ($urandom_range(99) < 92), (i == 0), (i == n_chars - 1) && !open_end);
    end
  endtask

  // Sender holds off until every predicted result has come out.
  task automatic settle_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int        pick;
    int        n_chars;
    lcd_word_t noise;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed words ----
    send_tick(16'h0000);                               // nothing queued: no result
    send_char(8'd1, 8'd1, 8'h55, 1'b1, 1'b0, 1'b1);    // stray word, marked last
    send_char(ROW_ONE, 8'd1, 8'h00, 1'b1, 1'b1, 1'b1); // single-word request, char 0x00
    send_char(ROW_TWO, MAX_COLUMN, 8'hFF, 1'b1, 1'b1, 1'b1);  // queue busy
    send_tick(16'h0000);                               // address 0x80
    send_tick(16'h0000);                               // same tick again: too early
    send_tick(16'h0001);                               // char, queue drains
    send_char(8'd0, 8'd1, 8'h31, 1'b1, 1'b1, 1'b1);    // bad row 0
    send_char(8'd3, 8'd5, 8'h32, 1'b1, 1'b1, 1'b1);    // bad row 3
    send_char(ROW_ONE, 8'd0, 8'h33, 1'b1, 1'b1, 1'b1); // bad column 0
    send_char(ROW_TWO, MAX_COLUMN + 8'd1, 8'h34, 1'b1, 1'b1, 1'b1);  // column 41
    send_char(8'hFF, 8'hFF, 8'h35, 1'b1, 1'b1, 1'b1);  // both out of range
    send_char(ROW_TWO, MAX_COLUMN, 8'h20, 1'b0, 1'b1, 1'b1);  // empty request, 0xE7
    send_tick(16'h8001);                               // lag 0x7FFF: still sends
    send_char(ROW_ONE, 8'd1, 8'h41, 1'b1, 1'b1, 1'b1);
    send_tick(16'h0002);                               // lag 0x8000: held back
    send_tick(16'hFFFF);                               // sends, limit wraps to 0
    send_tick(16'hFFFF);                               // behind the wrapped limit
    send_tick(16'h0000);                               // sends char 0x41
    send_char(ROW_ONE, 8'd2, 8'h61, 1'b1, 1'b1, 1'b0); // request left open
    send_tick(16'h0001);                               // tick inside the request
    send_tick(16'h0002);                               // drains it mid-request
    send_char(8'h00, 8'hFF, 8'h7E, 1'b1, 1'b0, 1'b1);  // lands in entry 0
    send_tick(16'h0003);

    // ---- random words, three idling phases ----
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 29;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (words_sent < (phase + 1) * WORD_TARGET / 3) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          random_request(n_chars);
          // usually enough ticks to drain, sometimes too few
          if ($urandom_range(99) < 75)
            repeat (n_chars + $urandom_range(1, 4)) send_tick(drift_tick());
          else
            repeat ($urandom_range(0, n_chars)) send_tick(drift_tick());
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 6)) send_tick(drift_tick());
        end else if (pick < 93) begin
          // not a first word: ignored unless a request is still open
          send_char(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b0,
                    1'($urandom));
        end else begin
          noise = lcd_word_t'({$urandom, ($bits(lcd_word_t) - 32)'($urandom)});
          tick_clock = noise.tick_now;
          send_word(noise);
        end
      end
      // pressure point: hold the sender until the block has emptied out
      settle_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input words: status ok %0d, bad row/column %0d, busy %0d, full %0d;",
             words_sent, ok_seen, bad_seen, busy_seen, full_seen);
    $display("%0d LCD writes checked, %0d mismatches.", writes_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_lcd_text_write_queue: PASS");
    end else begin
      $display("tb_lcd_text_write_queue: FAIL");
    end
    $finish;
  end

endmodule
